// ===== src/pid_controller_antiwindup_defines.svh =====
// Assertion macros for the PID controller block.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
`ifndef PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH

`ifndef SYNTH
`define PID_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pid assertion failed");
`define PID_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pid assertion failed");
`else
`define PID_ASSERT(lbl, clk, rstn, prop)
`define PID_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/pid_aw_pkg.sv =====
package pid_aw_pkg;

  localparam int SIGNAL_WIDTH_DEF   = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int GAIN_WIDTH         = 16;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D  = 3'd4;

endpackage

// ===== src/pid_aw_ifs.sv =====
interface pid_aw_in_if #(
  parameter int W = pid_aw_pkg::SIGNAL_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] target;
  logic signed [W-1:0] measured;
  logic signed [W-1:0] feed_forward;

  modport source (output valid, target, measured, feed_forward, input ready);
  modport sink   (input valid, target, measured, feed_forward, output ready);
endinterface

interface pid_aw_out_if #(
  parameter int W = pid_aw_pkg::SIGNAL_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] command;
  logic                saturated;

  modport source (output valid, command, saturated, input ready);
  modport sink   (input valid, command, saturated, output ready);
endinterface

// ===== src/pid_controller_antiwindup.sv =====
// Channel   Dir  Payload                             Handshake
// in_i      in   target, measured, feed_forward      valid/ready
// out_o     out  command, saturated                  valid/ready
// APB       in   out_max, out_min, gain_p/i/d        psel/penable, pready tied high
//
// One sample per cycle sustained while out_o.ready holds.
// Input register feeds one pass of multiply/add/clamp into the result register;
// the integral and previous measurement update at the same edge, so the next
// sample sees them at once. Reset (rst_ni low, async) clears state and gains and
// opens the limits to full range. A stalled result holds; the input register still
// fills behind it.
`include "pid_controller_antiwindup_defines.svh"

module pid_controller_antiwindup #(
  parameter int SIGNAL_WIDTH   = pid_aw_pkg::SIGNAL_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pid_aw_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pid_aw_in_if.sink                         in_i,
  pid_aw_out_if.source                      out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pid_aw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pid_aw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pid_aw_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);

  localparam int SW = SIGNAL_WIDTH;
  localparam int GF = GAIN_FRAC_BITS;
  localparam int GW = pid_aw_pkg::GAIN_WIDTH;
  localparam int IW = SW + GF;
  localparam int WW = SW + GW + 2;
  localparam int CW = WW + 2;
  localparam int DW = pid_aw_pkg::APB_DATA_W;

  // configuration
  logic signed [SW-1:0] out_max_q, out_min_q;
  logic [GW-1:0]        gain_p_q, gain_i_q, gain_d_q;
  logic                 cfg_we;
  logic [pid_aw_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[pid_aw_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_max_q <= {1'b0, {(SW-1){1'b1}}};
      out_min_q <= {1'b1, {(SW-1){1'b0}}};
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        pid_aw_pkg::REG_OUT_MAX: out_max_q <= pwdata[SW-1:0];
        pid_aw_pkg::REG_OUT_MIN: out_min_q <= pwdata[SW-1:0];
        pid_aw_pkg::REG_GAIN_P:  gain_p_q  <= pwdata[GW-1:0];
        pid_aw_pkg::REG_GAIN_I:  gain_i_q  <= pwdata[GW-1:0];
        pid_aw_pkg::REG_GAIN_D:  gain_d_q  <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pid_aw_pkg::REG_OUT_MAX: prdata = DW'(out_max_q);
      pid_aw_pkg::REG_OUT_MIN: prdata = DW'(out_min_q);
      pid_aw_pkg::REG_GAIN_P:  prdata = DW'(gain_p_q);
      pid_aw_pkg::REG_GAIN_I:  prdata = DW'(gain_i_q);
      pid_aw_pkg::REG_GAIN_D:  prdata = DW'(gain_d_q);
      default:                 prdata = '0;
    endcase
  end

  // pipeline control
  logic in_valid_q, out_valid_q, advance, in_take;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // input register
  logic signed [SW-1:0] tgt_q, meas_q, ff_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tgt_q  <= in_i.target;
      meas_q <= in_i.measured;
      ff_q   <= in_i.feed_forward;
    end
  end

  // loop state
  logic signed [IW-1:0] integ_q;
  logic signed [SW-1:0] last_meas_q;
  logic                 step;

  assign step = in_valid_q && advance;

  // datapath
  logic signed [SW:0]   err, change;
  logic signed [WW-1:0] inc, p_prod, d_prod, ihi, ilo, sum_i, integ_a, back_i, integ_n;
  logic signed [CW-1:0] cmd_raw, cmax, cmin, cmd_c;
  logic signed [SW-1:0] cmd_d;
  logic                 sat_d;

  always_comb begin
    err    = {tgt_q[SW-1], tgt_q} - {meas_q[SW-1], meas_q};
    change = {meas_q[SW-1], meas_q} - {last_meas_q[SW-1], last_meas_q};
    inc    = WW'(signed'({1'b0, gain_i_q}) * err);
    p_prod = WW'(signed'({1'b0, gain_p_q}) * err);
    d_prod = WW'(signed'({1'b0, gain_d_q}) * change);
    ihi    = WW'(out_max_q) <<< GF;
    ilo    = WW'(out_min_q) <<< GF;

    sum_i = WW'(integ_q) + inc;
    if (sum_i > ihi) begin
      integ_a = ihi;
    end else if (sum_i < ilo) begin
      integ_a = ilo;
    end else begin
      integ_a = sum_i;
    end

    // floor each term to integer, then sum exactly
    cmd_raw = CW'(p_prod >>> GF) + CW'(integ_a >>> GF) - CW'(d_prod >>> GF) + CW'(ff_q);
    cmax    = CW'(out_max_q);
    cmin    = CW'(out_min_q);
    sat_d   = 1'b0;
    if (cmd_raw > cmax) begin
      cmd_c = cmax;
      sat_d = 1'b1;
    end else if (cmd_raw < cmin) begin
      cmd_c = cmin;
      sat_d = 1'b1;
    end else begin
      cmd_c = cmd_raw;
    end

    // take back the increment on saturation and clamp again
    back_i = integ_a - inc;
    if (!sat_d) begin
      integ_n = integ_a;
    end else if (back_i > ihi) begin
      integ_n = ihi;
    end else if (back_i < ilo) begin
      integ_n = ilo;
    end else begin
      integ_n = back_i;
    end

    cmd_d = SW'(cmd_c);
    if (tgt_q > 0 && cmd_d < 0) begin
      cmd_d = '0;
    end else if (tgt_q < 0 && cmd_d > 0) begin
      cmd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_meas_q <= '0;
    end else if (step) begin
      integ_q     <= IW'(integ_n);
      last_meas_q <= meas_q;
    end
  end

  // result register
  logic signed [SW-1:0] cmd_q;
  logic                 sat_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      cmd_q <= cmd_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.command   = cmd_q;
  assign out_o.saturated = sat_q;

  `PID_ASSERT(a_full_blocks_input, clk_i, rst_ni, (in_valid_q && !advance) |-> !in_i.ready)
  `PID_ASSERT(a_step_fills_result, clk_i, rst_ni, step |=> out_valid_q)
  `PID_ASSERT(a_last_meas_tracks, clk_i, rst_ni, step |=> (last_meas_q == $past(meas_q)))
  `PID_ASSERT(a_sat_value, clk_i, rst_ni,
    (out_valid_q && sat_q) |-> (cmd_q == out_max_q || cmd_q == out_min_q || cmd_q == '0))
  `PID_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> (!in_valid_q && !out_valid_q))

endmodule

// ===== test/pid_controller_antiwindup_test.sv =====
`timescale 1ns / 1ps

module pid_controller_antiwindup_test;

  localparam int W            = pid_aw_pkg::SIGNAL_WIDTH_DEF;
  localparam int FRAC         = pid_aw_pkg::GAIN_FRAC_BITS_DEF;
  localparam int PHASE_ITEMS  = 200;
  localparam int RANDOM_PHASES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic [pid_aw_pkg::REG_IDX_W-1:0] reg_idx_t;

  typedef struct {
    logic signed [W-1:0] target;
    logic signed [W-1:0] measured;
    logic signed [W-1:0] feed_forward;
  } sample_t;

  typedef struct {
    logic signed [W-1:0] command;
    logic                saturated;
  } result_t;

  class loop_scoreboard;
    longint  lim_hi, lim_lo;
    longint  kp, ki, kd;
    longint  integ_acc, prev_meas;
    result_t pending_cmds[$];
    int      failures;

    function new();
      lim_hi    = (longint'(1) <<< (W - 1)) - 1;
      lim_lo    = -(longint'(1) <<< (W - 1));
      kp        = 0;
      ki        = 0;
      kd        = 0;
      integ_acc = 0;
      prev_meas = 0;
      failures  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] value);
      case (idx)
        pid_aw_pkg::REG_OUT_MAX: lim_hi = longint'($signed(value));
        pid_aw_pkg::REG_OUT_MIN: lim_lo = longint'($signed(value));
        pid_aw_pkg::REG_GAIN_P:  kp = longint'(value);
        pid_aw_pkg::REG_GAIN_I:  ki = longint'(value);
        pid_aw_pkg::REG_GAIN_D:  kd = longint'(value);
        default: ;
      endcase
    endfunction

    // upper limit wins; the lower one applies only when the upper did not
    function longint clip(input longint x, input longint hi, input longint lo,
                          inout bit hit);
      if (x > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (x < lo) begin
        hit = 1'b1;
        return lo;
      end
      return x;
    endfunction

    function void note_sample(sample_t s);
      longint  tgt, meas, err, inc, ihi, ilo, integ, cmd;
      bit      sat, ignored;
      result_t r;
      tgt     = s.target;
      meas    = s.measured;
      err     = tgt - meas;
      inc     = ki * err;
      ihi     = lim_hi * (longint'(1) <<< FRAC);
      ilo     = lim_lo * (longint'(1) <<< FRAC);
      sat     = 1'b0;
      ignored = 1'b0;
      integ   = clip(integ_acc + inc, ihi, ilo, ignored);
      cmd = ((kp * err) >>> FRAC) + (integ >>> FRAC)
          - ((kd * (meas - prev_meas)) >>> FRAC) + longint'(s.feed_forward);
      cmd = clip(cmd, lim_hi, lim_lo, sat);
      // take back this sample's increment when the command saturates
      if (sat)
        integ = clip(integ - inc, ihi, ilo, ignored);
      if ((tgt > 0 && cmd < 0) || (tgt < 0 && cmd > 0))
        cmd = 0;
      integ_acc   = integ;
      prev_meas   = meas;
      r.command   = cmd[W-1:0];
      r.saturated = sat;
      pending_cmds.push_back(r);
    endfunction

    function void check_command(result_t got);
      result_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: result with nothing expected: command %0d saturated %0b",
                 $time, got.command, got.saturated);
        failures++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got.command !== want.command) begin
        $display("%0t: command mismatch: expected %0d, actual %0d",
                 $time, want.command, got.command);
        failures++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
        failures++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [pid_aw_pkg::APB_ADDR_W-1:0] paddr;
  logic [pid_aw_pkg::APB_DATA_W-1:0] pwdata;
  logic [pid_aw_pkg::APB_DATA_W-1:0] prdata;
  logic                              pready;

  int unsigned    cycles = 0;
  longint         hold_target = 0;
  longint         walk_meas = 0;
  int             hold_left = 0;
  loop_scoreboard sb = new();

  pid_aw_in_if  #(.W(W)) in_if ();
  pid_aw_out_if #(.W(W)) out_if ();

  pid_controller_antiwindup #(
    .SIGNAL_WIDTH  (W),
    .GAIN_FRAC_BITS(FRAC)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check each transfer, then pick the next ready value
  initial begin
    result_t got;
    int      stall_mode;
    int      stall_left;
    stall_mode = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycles = cycles + 1;
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.command   = out_if.command;
        got.saturated = out_if.saturated;
        sb.check_command(got);
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (cycles[2:0] != 3'd5 && cycles[2:0] != 3'd6);
      endcase
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic apb_cycle(input bit wr, input reg_idx_t idx,
                           input logic [pid_aw_pkg::APB_DATA_W-1:0] wdata,
                           output logic [pid_aw_pkg::APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    logic [pid_aw_pkg::APB_DATA_W-1:0] wdata;
    logic [pid_aw_pkg::APB_DATA_W-1:0] rdata;
    if (idx == pid_aw_pkg::REG_OUT_MAX || idx == pid_aw_pkg::REG_OUT_MIN)
      wdata = {{(pid_aw_pkg::APB_DATA_W - 16){value[15]}}, value};
    else
      wdata = {{(pid_aw_pkg::APB_DATA_W - 16){1'b0}}, value};
    apb_cycle(1'b1, idx, wdata, rdata);
    apb_cycle(1'b0, idx, '0, rdata);
    if (rdata[15:0] !== value) begin
      $display("%0t: register %0d readback: expected %0h, actual %0h",
               $time, idx, value, rdata[15:0]);
      sb.failures++;
    end
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic signed [W-1:0] hi, input logic signed [W-1:0] lo,
                           input logic [15:0] gp, input logic [15:0] gi,
                           input logic [15:0] gd);
    write_reg(pid_aw_pkg::REG_OUT_MAX, hi);
    write_reg(pid_aw_pkg::REG_OUT_MIN, lo);
    write_reg(pid_aw_pkg::REG_GAIN_P, gp);
    write_reg(pid_aw_pkg::REG_GAIN_I, gi);
    write_reg(pid_aw_pkg::REG_GAIN_D, gd);
  endtask

  // keep valid high across back-to-back calls; the caller lowers it for a gap
  task automatic push_sample(input logic signed [W-1:0] tgt,
                             input logic signed [W-1:0] meas,
                             input logic signed [W-1:0] ff);
    sample_t s;
    s.target       = tgt;
    s.measured     = meas;
    s.feed_forward = ff;
    in_if.valid        <= 1'b1;
    in_if.target       <= tgt;
    in_if.measured     <= meas;
    in_if.feed_forward <= ff;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // a held setpoint with the measurement settling toward it, else a random sample at noise_pct percent
  function automatic sample_t next_sample(int noise_pct);
    sample_t s;
    longint  step;
    if ($urandom_range(0, 99) < noise_pct) begin
      s.target       = W'($urandom);
      s.measured     = W'($urandom);
      s.feed_forward = W'($urandom);
      return s;
    end
    if (hold_left == 0) begin
      hold_left = $urandom_range(4, 64);
      case ($urandom_range(0, 7))
        0:       hold_target = 0;
        1:       hold_target = $urandom_range(0, 1) ? 32767 : -32768;
        2, 3:    hold_target = longint'($urandom_range(0, 600)) - 300;
        default: hold_target = longint'($signed(W'($urandom)));
      endcase
    end
    hold_left = hold_left - 1;
    step      = (hold_target - walk_meas) / 4 + longint'($urandom_range(0, 64)) - 32;
    walk_meas = walk_meas + step;
    if (walk_meas > 32767)
      walk_meas = 32767;
    if (walk_meas < -32768)
      walk_meas = -32768;
    s.target   = hold_target[W-1:0];
    s.measured = walk_meas[W-1:0];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s.feed_forward = '0;
      5, 6, 7:       s.feed_forward = W'($urandom_range(0, 400) - 200);
      default:       s.feed_forward = W'($urandom);
    endcase
    return s;
  endfunction

  task automatic random_config();
    logic signed [W-1:0] hi;
    logic signed [W-1:0] lo;
    logic [15:0]         g[3];
    int                  r;
    case ($urandom_range(0, 5))
      0: begin
        hi = 16'sh7FFF;
        lo = 16'sh8000;
      end
      1, 2: begin
        r  = $urandom_range(1, 32767);
        hi = W'(r);
        lo = W'(-r);
      end
      3: begin
        hi = W'($urandom_range(0, 4000));
        lo = hi - W'($urandom_range(0, 8000));
      end
      4: begin
        hi = W'($urandom);
        lo = W'($urandom);
      end
      default: begin
        // crossed limits
        hi = W'(-$urandom_range(0, 500));
        lo = W'($urandom_range(1, 500));
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0:          g[k] = 16'h0000;
        1:          g[k] = 16'hFFFF;
        2, 3, 4, 5: g[k] = 16'($urandom_range(0, 16'h0100));
        6, 7:       g[k] = 16'($urandom_range(0, 16'h1000));
        default:    g[k] = 16'($urandom);
      endcase
    end
    configure(hi, lo, g[0], g[1], g[2]);
  endtask

  task automatic run_phase(input int count);
    sample_t s;
    int      noise_pct;
    int      sent;
    int      burst;
    int      gap;
    noise_pct = ($urandom_range(0, 3) == 0) ? 60 : 20;
    sent      = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        s = next_sample(noise_pct);
        push_sample(s.target, s.measured, s.feed_forward);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.target       <= '0;
    in_if.measured     <= '0;
    in_if.feed_forward <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limits and gains as after reset: command follows feed-forward unless its sign opposes the target
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
    push_sample(16'sd100, 16'sd0, -16'sd5);
    push_sample(-16'sd100, 16'sd0, 16'sd5);
    drain();

    // narrow limits: saturation both ways, integral take-back, zero target
    configure(16'sd1000, -16'sd1000, 16'h0100, 16'h0080, 16'h0040);
    push_sample(16'sd500, 16'sd0, 16'sd0);
    push_sample(16'sd30000, 16'sd0, 16'sd0);
    push_sample(-16'sd30000, 16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd2000, 16'sd0);
    push_sample(16'sd0, -16'sd2000, 16'sd0);
    push_sample(16'sd20, -16'sd20, -16'sd900);
    push_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF);
    drain();

    // fully crossed limits with maximum gains
    configure(16'sh8000, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sh7FFF, 16'sh8000, 16'sd0);
    push_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
    push_sample(16'sd1, 16'sd1, 16'sd1);
    drain();

    configure(-16'sd100, 16'sd100, 16'h0100, 16'h0100, 16'h0100);
    push_sample(16'sd50, 16'sd50, 16'sd50);
    push_sample(-16'sd50, 16'sd0, 16'sd0);
    drain();

    configure(16'sh7FFF, 16'sh8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(-16'sd1, 16'sd0, 16'sd0);
    push_sample(16'sd1, -16'sd1, -16'sd1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.failures == 0 && sb.pending_cmds.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/pid_aw_pkg.sv
src/pid_aw_ifs.sv
src/pid_controller_antiwindup.sv
test/pid_controller_antiwindup_test.sv
